FILE: rtl/core/hsp_pkg.sv
// ----------------------------------------------------------------------------
// hsp_pkg: shared types and codes for the HTTP status header parser
// Verdict and tag codes, character constants and the result record passed
// from the parse core to the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package hsp_pkg;

	// Verdict codes
	localparam logic [1:0] VERDICT_MORE = 2'd0;
	localparam logic [1:0] VERDICT_DONE = 2'd1;
	localparam logic [1:0] VERDICT_BAD  = 2'd2;

	// Byte tag codes
	localparam logic [2:0] TAG_NONE       = 3'd0;
	localparam logic [2:0] TAG_MSG        = 3'd1;
	localparam logic [2:0] TAG_NAME_FIRST = 3'd2;
	localparam logic [2:0] TAG_NAME       = 3'd3;
	localparam logic [2:0] TAG_VALUE      = 3'd4;

	// Command codes
	localparam logic CMD_PARSE   = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// Saturation limits
	localparam logic [7:0] VER_MAX  = 8'd255;
	localparam logic [9:0] CODE_MAX = 10'd1023;

	// Characters
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_CTL_MAX = 8'h1F;

	typedef struct packed {
		logic [1:0] verdict;
		logic [2:0] byte_tag;
		logic [7:0] out_byte;
		logic [7:0] version_major;
		logic [7:0] version_minor;
		logic [9:0] status_value;
	} hsp_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/hsp_ifs.sv
// ----------------------------------------------------------------------------
// hsp_ifs: channel interfaces of the HTTP status header parser
// Byte channel (command and data byte) and result channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsp_byte_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface hsp_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	logic [2:0] byte_tag;
	logic [7:0] out_byte;
	logic [7:0] version_major;
	logic [7:0] version_minor;
	logic [9:0] status_value;

	modport source (output valid, output verdict, output byte_tag, output out_byte,
		output version_major, output version_minor, output status_value,
		input ready);
	modport sink (input valid, input verdict, input byte_tag, input out_byte,
		input version_major, input version_minor, input status_value,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hsp_parse_core.sv
// ----------------------------------------------------------------------------
// hsp_parse_core: response head state machine
// Holds the parse state and the version and status accumulators, and works
// out the result of one beat from the current state and the byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hsp_parse_core import hsp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        cmd,
	input  wire logic [7:0]  data_byte,
	output hsp_result_t      result
);

	typedef enum logic [4:0] {
		ST_H, ST_T1, ST_T2, ST_P, ST_SLASH, ST_MAJ_START, ST_MAJ, ST_MIN_START,
		ST_MIN, ST_CODE, ST_MSG, ST_NL1, ST_LINE_START, ST_LWS, ST_NAME,
		ST_SP_VALUE, ST_VALUE, ST_NL2, ST_NL3, ST_DONE, ST_BAD
	} state_t;

	state_t     state_q, state_d;
	logic       hdr_seen_q, hdr_seen_d;
	logic [7:0] major_q, major_d;
	logic [7:0] minor_q, minor_d;
	logic [9:0] code_q, code_d;
	logic [1:0] verdict;
	logic [2:0] tag;

	function automatic logic is_ctl(input logic [7:0] b);
		return (b <= CH_CTL_MAX) || (b == CH_DEL);
	endfunction

	function automatic logic is_dec_char(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_token(input logic [7:0] b);
		logic sep;
		case (b)
			8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
			8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20,
			8'h09: sep = 1'b1;
			default: sep = 1'b0;
		endcase
		return !b[7] && !is_ctl(b) && !sep;
	endfunction

	// acc * 10 + digit, saturating at 255
	function automatic logic [7:0] dec_ver(input logic [7:0] acc, input logic [7:0] b);
		logic [11:0] v;
		v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, b[3:0]};
		return (v > {4'd0, VER_MAX}) ? VER_MAX : v[7:0];
	endfunction

	// acc * 10 + digit, saturating at 1023
	function automatic logic [9:0] dec_code(input logic [9:0] acc, input logic [7:0] b);
		logic [13:0] v;
		v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {10'd0, b[3:0]};
		return (v > {4'd0, CODE_MAX}) ? CODE_MAX : v[9:0];
	endfunction

	// Next state and result of one beat
	always_comb begin
		logic ok;
		ok         = 1'b1;
		state_d    = state_q;
		hdr_seen_d = hdr_seen_q;
		major_d    = major_q;
		minor_d    = minor_q;
		code_d     = code_q;
		verdict    = VERDICT_MORE;
		tag        = TAG_NONE;
		if (cmd == CMD_RESTART) begin
			state_d    = ST_H;
			hdr_seen_d = 1'b0;
			major_d    = '0;
			minor_d    = '0;
			code_d     = '0;
		end else begin
			unique case (state_q)
				ST_H: begin
					if (data_byte == CH_H) state_d = ST_T1; else ok = 1'b0;
				end
				ST_T1: begin
					if (data_byte == CH_T) state_d = ST_T2; else ok = 1'b0;
				end
				ST_T2: begin
					if (data_byte == CH_T) state_d = ST_P; else ok = 1'b0;
				end
				ST_P: begin
					if (data_byte == CH_P) state_d = ST_SLASH; else ok = 1'b0;
				end
				ST_SLASH: begin
					if (data_byte == CH_SLASH) begin
						major_d = '0;
						minor_d = '0;
						state_d = ST_MAJ_START;
					end else ok = 1'b0;
				end
				ST_MAJ_START: begin
					if (is_dec_char(data_byte)) begin
						major_d = dec_ver(major_q, data_byte);
						state_d = ST_MAJ;
					end else ok = 1'b0;
				end
				ST_MAJ: begin
					if (data_byte == CH_DOT) state_d = ST_MIN_START;
					else if (is_dec_char(data_byte)) major_d = dec_ver(major_q, data_byte);
					else ok = 1'b0;
				end
				ST_MIN_START: begin
					if (is_dec_char(data_byte)) begin
						minor_d = dec_ver(minor_q, data_byte);
						state_d = ST_MIN;
					end else ok = 1'b0;
				end
				ST_MIN: begin
					if (data_byte == CH_SP) begin
						code_d  = '0;
						state_d = ST_CODE;
					end else if (is_dec_char(data_byte)) minor_d = dec_ver(minor_q, data_byte);
					else ok = 1'b0;
				end
				ST_CODE: begin
					if (is_dec_char(data_byte)) code_d = dec_code(code_q, data_byte);
					else if (data_byte == CH_SP) state_d = ST_MSG;
					else ok = 1'b0;
				end
				ST_MSG: begin
					if (data_byte == CH_CR) state_d = ST_NL1;
					else if (!data_byte[7]) tag = TAG_MSG;
					else ok = 1'b0;
				end
				ST_NL1: begin
					if (data_byte == CH_LF) state_d = ST_LINE_START; else ok = 1'b0;
				end
				ST_LINE_START: begin
					if (data_byte == CH_CR) state_d = ST_NL3;
					else if (hdr_seen_q && (data_byte == CH_SP || data_byte == CH_HT))
						state_d = ST_LWS;
					else if (is_token(data_byte)) begin
						hdr_seen_d = 1'b1;
						tag        = TAG_NAME_FIRST;
						state_d    = ST_NAME;
					end else ok = 1'b0;
				end
				ST_LWS: begin
					if (data_byte == CH_CR) state_d = ST_NL2;
					else if (data_byte == CH_SP || data_byte == CH_HT) state_d = ST_LWS;
					else if (is_ctl(data_byte)) ok = 1'b0;
					else begin
						tag     = TAG_VALUE;
						state_d = ST_VALUE;
					end
				end
				ST_NAME: begin
					if (data_byte == CH_COLON) state_d = ST_SP_VALUE;
					else if (is_token(data_byte)) tag = TAG_NAME;
					else ok = 1'b0;
				end
				ST_SP_VALUE: begin
					if (data_byte == CH_SP) state_d = ST_VALUE; else ok = 1'b0;
				end
				ST_VALUE: begin
					if (data_byte == CH_CR) state_d = ST_NL2;
					else if (is_ctl(data_byte)) ok = 1'b0;
					else tag = TAG_VALUE;
				end
				ST_NL2: begin
					if (data_byte == CH_LF) state_d = ST_LINE_START; else ok = 1'b0;
				end
				ST_NL3: begin
					if (data_byte == CH_LF) begin
						state_d = ST_DONE;
						verdict = VERDICT_DONE;
					end else ok = 1'b0;
				end
				ST_DONE: begin
					verdict = VERDICT_DONE;
				end
				default: begin
					ok = 1'b0;
				end
			endcase
			// drop into the bad state on any unexpected byte
			if (!ok) begin
				state_d = ST_BAD;
				verdict = VERDICT_BAD;
				tag     = TAG_NONE;
			end
		end
	end

	// Assemble the result of this beat
	always_comb begin
		result.verdict       = verdict;
		result.byte_tag      = tag;
		result.out_byte      = (tag != TAG_NONE) ? data_byte : 8'd0;
		result.version_major = major_d;
		result.version_minor = minor_d;
		result.status_value  = code_d;
	end

	// Advance the parse state once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_H;
			hdr_seen_q <= 1'b0;
			major_q    <= '0;
			minor_q    <= '0;
			code_q     <= '0;
		end else if (step) begin
			state_q    <= state_d;
			hdr_seen_q <= hdr_seen_d;
			major_q    <= major_d;
			minor_q    <= minor_d;
			code_q     <= code_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/http_status_header_parser_unit.sv
// ----------------------------------------------------------------------------
// http_status_header_parser_unit: HTTP/1.x response head parser
// Input register, parse state machine, result register.
// ----------------------------------------------------------------------------
// Takes one byte per beat and answers each with one result beat: a verdict
// (more needed, complete, bad), the byte with its tag when it belongs to the
// status message or a header name or value, and the running version and
// status code. A restart command (cmd = 1) returns the parser to the start of
// the status line. The unit accepts one byte per clock cycle while the result
// channel does not stall; each byte is held in the input register, then passes
// through the combinational next-state logic of the parse state register into
// the result register. A stall on the result channel holds both registers and
// back-pressures the byte channel.
`default_nettype none

module http_status_header_parser_unit import hsp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	hsp_byte_if.sink     byte_ch,
	hsp_result_if.source result_ch
);

	logic        valid_s1;
	logic        cmd_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	hsp_result_t res_s2;
	hsp_result_t res;
	logic        adv;

	// Move the held byte into the result stage when that stage is free
	assign adv           = valid_s1 && (!valid_s2 || result_ch.ready);
	assign byte_ch.ready = !valid_s1 || adv;

	// Hold the accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.valid && byte_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			cmd_s1  <= byte_ch.cmd;
			byte_s1 <= byte_ch.data_byte;
		end
	end

	hsp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.cmd       (cmd_s1),
		.data_byte (byte_s1),
		.result    (res)
	);

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign result_ch.valid         = valid_s2;
	assign result_ch.verdict       = res_s2.verdict;
	assign result_ch.byte_tag      = res_s2.byte_tag;
	assign result_ch.out_byte      = res_s2.out_byte;
	assign result_ch.version_major = res_s2.version_major;
	assign result_ch.version_minor = res_s2.version_minor;
	assign result_ch.status_value  = res_s2.status_value;

endmodule

`default_nettype wire

FILE: rtl/core/hsp_checker.sv
// ----------------------------------------------------------------------------
// hsp_checker: port-level checks of the HTTP status header parser
// Watches the result channel and checks verdict, tag and payload relations.
// ----------------------------------------------------------------------------
`default_nettype none

module hsp_checker import hsp_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] verdict,
	input wire logic [2:0] byte_tag,
	input wire logic [7:0] out_byte
);

	// A tagged byte only comes with a verdict of more needed
	a_tag_more: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (byte_tag != TAG_NONE) |-> verdict == VERDICT_MORE)
		else $error("tagged byte with final verdict");

	// An untagged beat carries a zero byte
	a_untagged_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (byte_tag == TAG_NONE) |-> out_byte == 8'd0)
		else $error("untagged beat with nonzero byte");

	// Codes stay within their defined range
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict <= VERDICT_BAD) && (byte_tag <= TAG_VALUE))
		else $error("undefined verdict or tag code");

	// A stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict)
			&& $stable(byte_tag) && $stable(out_byte))
		else $error("stalled result beat changed");

endmodule

bind http_status_header_parser_unit hsp_checker u_hsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result_ch.valid),
	.out_ready (result_ch.ready),
	.verdict   (result_ch.verdict),
	.byte_tag  (result_ch.byte_tag),
	.out_byte  (result_ch.out_byte)
);

`default_nettype wire

FILE: test/http_status_header_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// http_status_header_parser_unit_tb: self-checking bench for the response parser
// Feeds restart commands and byte streams that form response heads, some of
// them broken, into the byte channel. A scoreboard predicts the result beat of
// every accepted byte and compares it with the result channel. Both channels
// idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module http_status_header_parser_unit_tb;
	import hsp_pkg::*;

	// Parser states of the prediction
	typedef enum logic [4:0] {
		PS_H, PS_T1, PS_T2, PS_P, PS_SLASH, PS_MAJ0, PS_MAJ, PS_MIN0, PS_MIN,
		PS_CODE, PS_MSG, PS_NL1, PS_LINE, PS_LWS, PS_NAME, PS_SPV, PS_VALUE,
		PS_NL2, PS_NL3, PS_DONE, PS_BAD
	} parse_state_t;

	// Receiver stall modes
	localparam logic [1:0] RX_OPEN   = 2'd0;
	localparam logic [1:0] RX_COIN   = 2'd1;
	localparam logic [1:0] RX_SPARSE = 2'd2;
	localparam logic [1:0] RX_MOSTLY = 2'd3;

	localparam int NUM_BYTES = 1550;

	typedef struct {
		logic       c;
		logic [7:0] d;
	} beat_t;

	// Predicts one result beat per accepted byte and holds them in order
	class head_scoreboard;
		parse_state_t st;
		bit           hdr_seen;
		int           maj;
		int           mnr;
		int           code;
		hsp_result_t  due[$];

		function new();
			clear();
		endfunction

		function void clear();
			st = PS_H;
			hdr_seen = 0;
			maj = 0;
			mnr = 0;
			code = 0;
		endfunction

		function bit is_ctl(logic [7:0] b);
			return (b <= CH_CTL_MAX) || (b == CH_DEL);
		endfunction

		function bit is_dec(logic [7:0] b);
			return (b >= CH_ZERO) && (b <= CH_NINE);
		endfunction

		function bit is_token(logic [7:0] b);
			if (b > CH_DEL || is_ctl(b))
				return 0;
			case (b)
				"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]",
				"?", "=", "{", "}", CH_SP, CH_HT: return 0;
				default: return 1;
			endcase
		endfunction

		function int dec_sat(int acc, logic [7:0] b, int top);
			int v;
			v = acc * 10 + (b - CH_ZERO);
			return (v > top) ? top : v;
		endfunction

		function int pending();
			return due.size();
		endfunction

		// Advance the state by one accepted beat and queue its result
		function void note_byte(logic c, logic [7:0] b);
			hsp_result_t r;
			bit ok;
			ok = 1;
			r.verdict = VERDICT_MORE;
			r.byte_tag = TAG_NONE;
			if (c == CMD_RESTART) begin
				clear();
			end else begin
				case (st)
					PS_H:  if (b == CH_H) st = PS_T1; else ok = 0;
					PS_T1: if (b == CH_T) st = PS_T2; else ok = 0;
					PS_T2: if (b == CH_T) st = PS_P; else ok = 0;
					PS_P:  if (b == CH_P) st = PS_SLASH; else ok = 0;
					PS_SLASH: begin
						if (b == CH_SLASH) begin
							maj = 0;
							mnr = 0;
							st = PS_MAJ0;
						end else ok = 0;
					end
					PS_MAJ0: begin
						if (is_dec(b)) begin
							maj = dec_sat(maj, b, VER_MAX);
							st = PS_MAJ;
						end else ok = 0;
					end
					PS_MAJ: begin
						if (b == CH_DOT) st = PS_MIN0;
						else if (is_dec(b)) maj = dec_sat(maj, b, VER_MAX);
						else ok = 0;
					end
					PS_MIN0: begin
						if (is_dec(b)) begin
							mnr = dec_sat(mnr, b, VER_MAX);
							st = PS_MIN;
						end else ok = 0;
					end
					PS_MIN: begin
						if (b == CH_SP) begin
							code = 0;
							st = PS_CODE;
						end else if (is_dec(b)) mnr = dec_sat(mnr, b, VER_MAX);
						else ok = 0;
					end
					PS_CODE: begin
						if (is_dec(b)) code = dec_sat(code, b, CODE_MAX);
						else if (b == CH_SP) st = PS_MSG;
						else ok = 0;
					end
					PS_MSG: begin
						if (b == CH_CR) st = PS_NL1;
						else if (b <= CH_DEL) r.byte_tag = TAG_MSG;
						else ok = 0;
					end
					PS_NL1: if (b == CH_LF) st = PS_LINE; else ok = 0;
					PS_LINE: begin
						if (b == CH_CR) st = PS_NL3;
						else if (hdr_seen && (b == CH_SP || b == CH_HT)) st = PS_LWS;
						else if (is_token(b)) begin
							hdr_seen = 1;
							r.byte_tag = TAG_NAME_FIRST;
							st = PS_NAME;
						end else ok = 0;
					end
					PS_LWS: begin
						if (b == CH_CR) st = PS_NL2;
						else if (b == CH_SP || b == CH_HT) st = PS_LWS;
						else if (is_ctl(b)) ok = 0;
						else begin
							r.byte_tag = TAG_VALUE;
							st = PS_VALUE;
						end
					end
					PS_NAME: begin
						if (b == CH_COLON) st = PS_SPV;
						else if (is_token(b)) r.byte_tag = TAG_NAME;
						else ok = 0;
					end
					PS_SPV: if (b == CH_SP) st = PS_VALUE; else ok = 0;
					PS_VALUE: begin
						if (b == CH_CR) st = PS_NL2;
						else if (is_ctl(b)) ok = 0;
						else r.byte_tag = TAG_VALUE;
					end
					PS_NL2: if (b == CH_LF) st = PS_LINE; else ok = 0;
					PS_NL3: begin
						if (b == CH_LF) begin
							st = PS_DONE;
							r.verdict = VERDICT_DONE;
						end else ok = 0;
					end
					PS_DONE: r.verdict = VERDICT_DONE;
					default: ok = 0;
				endcase
				// Any rejected byte parks the parser until restart
				if (!ok) begin
					st = PS_BAD;
					r.verdict = VERDICT_BAD;
					r.byte_tag = TAG_NONE;
				end
			end
			r.out_byte = (r.byte_tag != TAG_NONE) ? b : 8'd0;
			r.version_major = maj[7:0];
			r.version_minor = mnr[7:0];
			r.status_value = code[9:0];
			due.insert(due.size(), r);
		endfunction

		// Compare one result beat with the oldest prediction
		function bit check_result(hsp_result_t got, output string why);
			hsp_result_t exp_r;
			why = "";
			if (due.size() == 0) begin
				why = "result beat with no byte outstanding";
				return 0;
			end
			exp_r = due.pop_front();
			if (got.verdict !== exp_r.verdict)
				why = {why, $sformatf(" verdict %0d/%0d", got.verdict, exp_r.verdict)};
			if (got.byte_tag !== exp_r.byte_tag)
				why = {why, $sformatf(" byte_tag %0d/%0d", got.byte_tag, exp_r.byte_tag)};
			if (got.out_byte !== exp_r.out_byte)
				why = {why, $sformatf(" out_byte %h/%h", got.out_byte, exp_r.out_byte)};
			if (got.version_major !== exp_r.version_major)
				why = {why, $sformatf(" version_major %0d/%0d", got.version_major,
					exp_r.version_major)};
			if (got.version_minor !== exp_r.version_minor)
				why = {why, $sformatf(" version_minor %0d/%0d", got.version_minor,
					exp_r.version_minor)};
			if (got.status_value !== exp_r.status_value)
				why = {why, $sformatf(" status_value %0d/%0d", got.status_value,
					exp_r.status_value)};
			if (why != "") begin
				why = {"mismatch (got/expected):", why};
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   errors;

	logic [1:0] rx_mode;
	logic [5:0] rx_cnt;

	head_scoreboard sb;
	beat_t          plan[$];
	beat_t          head[$];
	string          tok_chars;

	hsp_byte_if   byte_ch();
	hsp_result_if result_ch();

	http_status_header_parser_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	// Clock, period 20
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop for a hung run
	initial begin
		#10000000;
		$display("http_status_header_parser_unit_tb: FAIL");
		$finish;
	end

	task report(string msg);
		errors++;
		if (errors <= 100)
			$display("%0t: %s", $time, msg);
	endtask

	// Receiver stalls on a mode that changes each time rx_cnt wraps
	always @(posedge clk) begin
		rx_cnt <= rx_cnt + 6'd1;
		if (rx_cnt == 6'd0)
			rx_mode <= 2'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:   result_ch.ready <= 1'b1;
			RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: result_ch.ready <= (rx_cnt[1:0] == 2'd0);
			default:   result_ch.ready <= ($urandom_range(0, 4) != 0);
		endcase
	end

	// Watch both channels: check result beats, predict from byte beats
	always @(posedge clk) begin : watch
		hsp_result_t got;
		string       why;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got.verdict = result_ch.verdict;
				got.byte_tag = result_ch.byte_tag;
				got.out_byte = result_ch.out_byte;
				got.version_major = result_ch.version_major;
				got.version_minor = result_ch.version_minor;
				got.status_value = result_ch.status_value;
				if (!sb.check_result(got, why))
					report(why);
			end
			if (byte_ch.valid && byte_ch.ready)
				sb.note_byte(byte_ch.cmd, byte_ch.data_byte);
		end
	end

	function void put(logic [7:0] d);
		head.insert(head.size(), '{c: CMD_PARSE, d: d});
	endfunction

	function void put_digits(int n);
		repeat (n) put(8'($urandom_range(CH_ZERO, CH_NINE)));
	endfunction

	function void put_value(int n);
		logic [7:0] x;
		repeat (n) begin
			x = 8'($urandom_range(32, 255));
			if (x == CH_DEL)
				x = 8'h80;
			put(x);
		end
	endfunction

	function logic [7:0] lws();
		return $urandom_range(0, 1) ? CH_SP : CH_HT;
	endfunction

	function void put_crlf();
		put(CH_CR);
		put(CH_LF);
	endfunction

	// Build one response head with random content, sometimes broken
	task automatic add_head();
		int         variant;
		int         pos;
		logic [7:0] x;
		head.delete();
		head.insert(head.size(), '{c: CMD_RESTART, d: 8'($urandom)});
		variant = $urandom_range(0, 11);
		put(CH_H);
		put(CH_T);
		put(CH_T);
		put(CH_P);
		put(CH_SLASH);
		put_digits(($urandom_range(0, 6) == 0) ? $urandom_range(3, 4) : 1);
		put(CH_DOT);
		put_digits(($urandom_range(0, 6) == 0) ? $urandom_range(3, 4) : 1);
		put(CH_SP);
		put_digits(($urandom_range(0, 5) == 0) ? $urandom_range(4, 5) : $urandom_range(1, 3));
		put(CH_SP);
		repeat ($urandom_range(0, 6)) begin
			x = 8'($urandom_range(0, 127));
			if (x == CH_CR)
				x = CH_SP;
			put(x);
		end
		put_crlf();
		// Folded line with no header before it must be rejected
		if (variant == 2) begin
			put(lws());
			put_value($urandom_range(0, 3));
			put_crlf();
		end
		repeat ((variant == 2) ? 0 : $urandom_range(0, 3)) begin
			repeat ($urandom_range(1, 5))
				put(8'(tok_chars[$urandom_range(0, tok_chars.len() - 1)]));
			put(CH_COLON);
			put(CH_SP);
			put_value($urandom_range(0, 5));
			put_crlf();
			repeat ($urandom_range(0, 2)) begin
				put(lws());
				repeat ($urandom_range(0, 2)) put(lws());
				put_value($urandom_range(0, 4));
				put_crlf();
			end
		end
		put_crlf();
		// Trailing bytes after the head are ignored
		repeat ($urandom_range(0, 2)) put(8'($urandom));
		pos = $urandom_range(1, head.size() - 1);
		case (variant)
			0: head[pos].d = 8'($urandom);
			1: while (head.size() > pos) void'(head.pop_back());
			3: head.insert(pos, '{c: CMD_RESTART, d: 8'($urandom)});
			default: ;
		endcase
		foreach (head[i]) plan.insert(plan.size(), head[i]);
	endtask

	// Present one beat and hold it until the parser takes it
	task drive_beat(beat_t bt);
		byte_ch.valid <= 1'b1;
		byte_ch.cmd <= bt.c;
		byte_ch.data_byte <= bt.d;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
	endtask

	initial begin : main
		string directed;
		int    burst;
		int    gap;
		byte_ch.valid = 1'b0;
		byte_ch.cmd = CMD_PARSE;
		byte_ch.data_byte = 8'd0;
		result_ch.ready = 1'b0;
		arst_n = 1'b0;
		rx_mode = RX_OPEN;
		rx_cnt = 6'd0;
		errors = 0;
		sb = new();
		tok_chars = {"!#$%&'*+-.^_|~0123456789",
			"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz"};

		// Directed: a short complete head, bytes after done, a bad start
		directed = "HTTP/1.1 200 K\r\n\r\n";
		plan.insert(plan.size(), '{c: CMD_RESTART, d: 8'hFF});
		for (int i = 0; i < directed.len(); i++)
			plan.insert(plan.size(), '{c: CMD_PARSE, d: 8'(directed[i])});
		plan.insert(plan.size(), '{c: CMD_PARSE, d: 8'hFF});
		plan.insert(plan.size(), '{c: CMD_RESTART, d: 8'h00});
		plan.insert(plan.size(), '{c: CMD_PARSE, d: 8'h00});
		plan.insert(plan.size(), '{c: CMD_PARSE, d: 8'hFF});

		// Random heads with some noise between them
		while (plan.size() < NUM_BYTES) begin
			add_head();
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 8))
					plan.insert(plan.size(),
						'{c: ($urandom_range(0, 7) == 0), d: 8'($urandom)});
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Send in bursts with random gaps
		burst = $urandom_range(1, 20);
		foreach (plan[i]) begin
			if (burst == 0) begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				burst = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
				if (gap > 0) begin
					byte_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			drive_beat(plan[i]);
			burst--;
		end
		byte_ch.valid <= 1'b0;

		// Drain until every predicted result beat has been checked
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("http_status_header_parser_unit_tb: PASS");
		else
			$display("http_status_header_parser_unit_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/hsp_pkg.sv
rtl/core/hsp_ifs.sv
rtl/core/hsp_parse_core.sv
rtl/core/http_status_header_parser_unit.sv
rtl/core/hsp_checker.sv
test/http_status_header_parser_unit_tb.sv
